// ===== hw/rtl/tcw_pkg.sv =====
// tcw_pkg: shared widths, codes and constants for the text console writer.
// No dependencies; compiled first.
package tcw_pkg;

   // field widths fixed by the word formats
   localparam int ACTION_W   = 2;
   localparam int CHAR_W     = 8;
   localparam int ATTR_W     = 8;
   localparam int ROW_W      = 5;
   localparam int COL_W      = 7;
   localparam int WORD_W     = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;

   // grid defaults
   localparam int DEF_COLUMNS = 80;
   localparam int DEF_ROWS    = 25;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_INDENT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOME   = 1'd1;

   // register reset values
   localparam logic [COL_W-1:0] INDENT_RESET = 7'd2;
   localparam logic [ROW_W-1:0] HOME_RESET   = 5'd1;

   // cell constants
   localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
   localparam logic [ATTR_W-1:0] BLANK_ATTR   = 8'h07;
   localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;

endpackage

// ===== hw/rtl/tcw_if.sv =====
// tcw_if: valid/ready channel interfaces for request, response and csr words.
// Depends on tcw_pkg.
interface tcw_req_if;
   import tcw_pkg::*;
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [CHAR_W-1:0]   char_code;
   logic [ATTR_W-1:0]   attribute;
   logic [ROW_W-1:0]    read_row;
   logic [COL_W-1:0]    read_col;

   modport source (output valid, action, char_code, attribute, read_row, read_col,
                   input ready);
   modport sink   (input valid, action, char_code, attribute, read_row, read_col,
                   output ready);
endinterface

interface tcw_rsp_if;
   import tcw_pkg::*;
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] cell_word;
   logic [COL_W-1:0]  cursor_col;
   logic [ROW_W-1:0]  cursor_row;

   modport source (output valid, cell_word, cursor_col, cursor_row, input ready);
   modport sink   (input valid, cell_word, cursor_col, cursor_row, output ready);
endinterface

interface tcw_csr_if;
   import tcw_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/text_console_writer.sv =====
// text_console_writer: ROWS x COLUMNS text grid with cursor, one cell RAM.
// Depends on tcw_pkg and tcw_if.
//
// One request word in, one response word out. A put or clear passes accept,
// update and the response register, which waits until the previous response
// is taken; a read adds a load step for the cell RAM read, skipped when the
// cell is off the grid or its row is flagged blank. The first non-newline
// byte written into a row that was blanked by reset, clear or scroll first
// has that row swept to blanks through the single RAM write port, and the
// update step then runs again before the byte lands. Scroll never moves data:
// a top-row pointer rotates logical rows onto physical RAM rows, and a per-row
// blank flag (flip-flops, set by reset, clear and scroll) makes a flagged row
// read as space/0x07. So there is no clearing pass after reset. A new request
// is taken while the previous response still waits on the response register.
// Csr writes are always taken; indent_column values at or past the right
// edge act as the last column, home_row values past the bottom act as the
// last row.
module text_console_writer #(
   parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
   parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
   input  logic      clock,
   input  logic      reset,
   tcw_req_if.sink   req_port,
   tcw_rsp_if.source rsp_port,
   tcw_csr_if.sink   csr_port
);
   import tcw_pkg::*;

   localparam int DEPTH   = ROWS * COLUMNS;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int PROW_W  = $clog2(ROWS);
   localparam int SWEEP_W = $clog2(COLUMNS);
   localparam int COLX_W  = COL_W + 1;
   localparam int ROWX_W  = ROW_W + 1;
   localparam int CELL_W  = ATTR_W + CHAR_W;

   // sequencer states
   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] ST_IDLE  = 3'd0;
   localparam logic [ST_W-1:0] ST_EXEC  = 3'd1;
   localparam logic [ST_W-1:0] ST_SWEEP = 3'd2;
   localparam logic [ST_W-1:0] ST_LOAD  = 3'd3;
   localparam logic [ST_W-1:0] ST_DONE  = 3'd4;

   // logical row -> physical RAM row, rotated by the top pointer
   function automatic logic [PROW_W-1:0] to_phys(input logic [ROW_W-1:0] lrow,
                                                 input logic [PROW_W-1:0] top);
      logic [ROWX_W-1:0] sum;
      sum = {1'b0, lrow} + ROWX_W'(top);
      if (sum >= ROWX_W'(ROWS)) begin
         sum = sum - ROWX_W'(ROWS);
      end
      return PROW_W'(sum);
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [PROW_W-1:0] prow,
                                                   input logic [COL_W-1:0]  col);
      return ADDR_W'(prow) * ADDR_W'(COLUMNS) + ADDR_W'(col);
   endfunction

   // control registers
   logic [ST_W-1:0]    state_ff,     state_in;
   logic [COL_W-1:0]   cur_col_ff,   cur_col_in;
   logic [ROW_W-1:0]   cur_row_ff,   cur_row_in;
   logic [PROW_W-1:0]  top_ff,       top_in;
   logic [ROWS-1:0]    blank_ff,     blank_in;
   logic [COL_W-1:0]   indent_ff,    indent_in;
   logic [ROW_W-1:0]   home_ff,      home_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [ACTION_W-1:0] act_ff,      act_in;
   logic [CHAR_W-1:0]   char_ff,     char_in;
   logic [ATTR_W-1:0]   attr_ff,     attr_in;
   logic [ROW_W-1:0]    rrow_ff,     rrow_in;
   logic [COL_W-1:0]    rcol_ff,     rcol_in;
   logic [SWEEP_W-1:0]  sweep_ff,    sweep_in;
   logic [WORD_W-1:0]   word_ff,     word_in;
   logic [WORD_W-1:0]   rsp_word_ff, rsp_word_in;
   logic [COL_W-1:0]    rsp_col_ff,  rsp_col_in;
   logic [ROW_W-1:0]    rsp_row_ff,  rsp_row_in;

   // cell RAM: attribute in the high byte, character in the low byte
   logic [CELL_W-1:0] cell_mem [DEPTH];
   logic [CELL_W-1:0] rdata_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [CELL_W-1:0] mem_wdata;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_raddr;

   logic              req_take;
   logic              rsp_free;
   logic [COL_W-1:0]  eff_indent;
   logic [ROW_W-1:0]  eff_home;
   logic [PROW_W-1:0] cur_phys;
   logic [PROW_W-1:0] rd_phys;
   logic [PROW_W-1:0] top_next;
   logic              rd_in_grid;
   logic [COLX_W-1:0] col_inc;
   logic [ROWX_W-1:0] row_inc;
   logic [COLX_W-1:0] adv_col;
   logic [ROWX_W-1:0] adv_row;
   logic              is_newline;
   logic              scroll;

   assign req_port.ready = (state_ff == ST_IDLE);
   assign req_take       = req_port.valid && req_port.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_port.ready;

   assign csr_port.ready = 1'b1;

   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.cell_word  = rsp_word_ff;
   assign rsp_port.cursor_col = rsp_col_ff;
   assign rsp_port.cursor_row = rsp_row_ff;

   // clamp registers into the grid
   assign eff_indent = ({1'b0, indent_ff} >= COLX_W'(COLUMNS)) ? COL_W'(COLUMNS - 1)
                                                                : indent_ff;
   assign eff_home   = ({1'b0, home_ff} >= ROWX_W'(ROWS)) ? ROW_W'(ROWS - 1) : home_ff;

   assign cur_phys   = to_phys(cur_row_ff, top_ff);
   assign rd_phys    = to_phys(rrow_ff, top_ff);
   assign top_next   = (top_ff == PROW_W'(ROWS - 1)) ? '0 : top_ff + 1'b1;
   assign rd_in_grid = ({1'b0, rrow_ff} < ROWX_W'(ROWS)) &&
                       ({1'b0, rcol_ff} < COLX_W'(COLUMNS));

   // cursor advance for a put; newline goes to indent of next row
   assign is_newline = (char_ff == NEWLINE_CHAR);
   assign col_inc    = {1'b0, cur_col_ff} + 1'b1;
   assign row_inc    = {1'b0, cur_row_ff} + 1'b1;

   always_comb begin
      if (is_newline) begin
         adv_col = {1'b0, eff_indent};
         adv_row = row_inc;
      end else if (col_inc >= COLX_W'(COLUMNS)) begin
         adv_col = '0;
         adv_row = row_inc;
      end else begin
         adv_col = col_inc;
         adv_row = {1'b0, cur_row_ff};
      end
   end

   assign scroll = (adv_row >= ROWX_W'(ROWS));

   always_comb begin
      state_in     = state_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      top_in       = top_ff;
      blank_in     = blank_ff;
      indent_in    = indent_ff;
      home_in      = home_ff;
      rsp_valid_in = rsp_valid_ff;
      act_in       = act_ff;
      char_in      = char_ff;
      attr_in      = attr_ff;
      rrow_in      = rrow_ff;
      rcol_in      = rcol_ff;
      sweep_in     = sweep_ff;
      word_in      = word_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      mem_we       = 1'b0;
      mem_waddr    = cell_addr(cur_phys, cur_col_ff);
      mem_wdata    = {attr_ff, char_ff};
      mem_re       = 1'b0;
      mem_raddr    = cell_addr(rd_phys, rcol_ff);

      if (csr_port.valid) begin
         unique case (csr_port.index)
            CSR_INDENT: indent_in = COL_W'(csr_port.data);
            CSR_HOME:   home_in   = ROW_W'(csr_port.data);
            default:    ;
         endcase
      end

      if (rsp_valid_ff && rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               act_in   = req_port.action;
               char_in  = req_port.char_code;
               attr_in  = req_port.attribute;
               rrow_in  = req_port.read_row;
               rcol_in  = req_port.read_col;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            word_in  = '0;
            state_in = ST_DONE;
            case (act_ff)
               ACT_PUT: begin
                  if (!is_newline && blank_ff[cur_phys]) begin
                     // row still holds stale cells: sweep it first
                     sweep_in = '0;
                     state_in = ST_SWEEP;
                  end else begin
                     mem_we = !is_newline;
                     if (scroll) begin
                        top_in         = top_next;
                        blank_in[top_ff] = 1'b1;  // old top row becomes bottom
                        cur_col_in     = eff_indent;
                        cur_row_in     = ROW_W'(ROWS - 1);
                     end else begin
                        cur_col_in = COL_W'(adv_col);
                        cur_row_in = ROW_W'(adv_row);
                     end
                  end
               end
               ACT_CLEAR: begin
                  blank_in   = '1;
                  cur_col_in = eff_indent;
                  cur_row_in = eff_home;
               end
               ACT_READ: begin
                  if (rd_in_grid) begin
                     if (blank_ff[rd_phys]) begin
                        word_in = {BLANK_ATTR, BLANK_CHAR};
                     end else begin
                        mem_re   = 1'b1;
                        state_in = ST_LOAD;
                     end
                  end
               end
               default: ;
            endcase
         end
         ST_SWEEP: begin
            mem_we    = 1'b1;
            mem_waddr = cell_addr(cur_phys, COL_W'(sweep_ff));
            mem_wdata = {BLANK_ATTR, BLANK_CHAR};
            if (sweep_ff == SWEEP_W'(COLUMNS - 1)) begin
               blank_in[cur_phys] = 1'b0;
               state_in           = ST_EXEC;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         ST_LOAD: begin
            word_in  = rdata_ff;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = word_ff;
               rsp_col_in   = cur_col_ff;
               rsp_row_in   = cur_row_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_col_ff   <= INDENT_RESET;
         cur_row_ff   <= HOME_RESET;
         top_ff       <= '0;
         blank_ff     <= '1;
         indent_ff    <= INDENT_RESET;
         home_ff      <= HOME_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         top_ff       <= top_in;
         blank_ff     <= blank_in;
         indent_ff    <= indent_in;
         home_ff      <= home_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      char_ff     <= char_in;
      attr_ff     <= attr_in;
      rrow_ff     <= rrow_in;
      rcol_ff     <= rcol_in;
      sweep_ff    <= sweep_in;
      word_ff     <= word_in;
      rsp_word_ff <= rsp_word_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= cell_mem[mem_raddr];
      end
   end

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for text_console_writer: directed and random words
// checked against an in-bench model of the character/attribute grid and cursor.
// Depends on tcw_pkg and the tcw_if interfaces in hw/rtl.
`timescale 1ns / 1ps

module testbench;
   import tcw_pkg::*;

   localparam int COLS  = DEF_COLUMNS;
   localparam int NROWS = DEF_ROWS;

   // the package names three actions; the fourth code is a no-op
   localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

   // printable range used for text
   localparam logic [CHAR_W-1:0] FIRST_PRINTABLE = 8'h21;
   localparam logic [CHAR_W-1:0] LAST_PRINTABLE  = 8'h7E;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [CHAR_W-1:0]   char_code;
      logic [ATTR_W-1:0]   attribute;
      logic [ROW_W-1:0]    read_row;
      logic [COL_W-1:0]    read_col;
   } console_cmd_type;

   typedef struct packed {
      logic [WORD_W-1:0] cell_word;
      logic [COL_W-1:0]  cursor_col;
      logic [ROW_W-1:0]  cursor_row;
   } console_reply_type;

   logic clock;
   logic reset;

   tcw_req_if req_bus ();
   tcw_rsp_if rsp_bus ();
   tcw_csr_if csr_bus ();

   text_console_writer #(
      .COLUMNS (COLS),
      .ROWS    (NROWS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus.sink),
      .rsp_port (rsp_bus.source),
      .csr_port (csr_bus.sink)
   );

   // 2 ns period
   initial clock = 1'b0;
   always #1 clock = ~clock;

   // ------------------------------------------------------------------
   // Console model: grid contents, cursor and the two registers.
   // ------------------------------------------------------------------
   logic [CHAR_W-1:0] grid_char [NROWS][COLS];
   logic [ATTR_W-1:0] grid_attr [NROWS][COLS];
   int                cur_x;          // cursor column
   int                cur_y;          // cursor row
   logic [COL_W-1:0]  indent_reg;
   logic [ROW_W-1:0]  home_reg;

   // expected replies, oldest first
   console_reply_type reply_q [$];
   int                mismatch_count = 0;

   // idling knobs for sender and receiver
   bit                calm = 1'b0;    // no idling at all
   int                send_idle_pct = 20;
   int                stall_pct = 20;
   int                hold_request = 0;
   int                hold_left = 0;
   int                stall_left = 0;

   // indent / home past the grid clamp to the last column / row
   function automatic int indent_eff();
      return (int'(indent_reg) < COLS) ? int'(indent_reg) : COLS - 1;
   endfunction

   function automatic int home_eff();
      return (int'(home_reg) < NROWS) ? int'(home_reg) : NROWS - 1;
   endfunction

   task automatic blank_row(input int r);
      for (int c = 0; c < COLS; c++) begin
         grid_char[r][c] = BLANK_CHAR;
         grid_attr[r][c] = BLANK_ATTR;
      end
   endtask

   task automatic blank_grid();
      for (int r = 0; r < NROWS; r++) blank_row(r);
   endtask

   // everything moves up one row, bottom row blank, cursor to indent of last row
   task automatic scroll_grid();
      for (int r = 0; r < NROWS - 1; r++) begin
         for (int c = 0; c < COLS; c++) begin
            grid_char[r][c] = grid_char[r+1][c];
            grid_attr[r][c] = grid_attr[r+1][c];
         end
      end
      blank_row(NROWS - 1);
      cur_x = indent_eff();
      cur_y = NROWS - 1;
   endtask

   task automatic reset_console();
      indent_reg = INDENT_RESET;
      home_reg   = HOME_RESET;
      blank_grid();
      cur_x = indent_eff();
      cur_y = home_eff();
   endtask

   task automatic set_console_reg(input logic [CSR_IDX_W-1:0] idx,
                                  input logic [CSR_DATA_W-1:0] value);
      if (idx == CSR_INDENT) begin
         indent_reg = value[COL_W-1:0];
      end else if (idx == CSR_HOME) begin
         home_reg = value[ROW_W-1:0];
      end
   endtask

   // apply one command word to the model and build the reply it must produce
   task automatic advance_console(input console_cmd_type cmd,
                                  output console_reply_type reply);
      reply.cell_word = '0;
      case (cmd.action)
         ACT_PUT: begin
            if (cmd.char_code == NEWLINE_CHAR) begin
               cur_x = indent_eff();
               cur_y++;
            end else begin
               grid_char[cur_y][cur_x] = cmd.char_code;
               grid_attr[cur_y][cur_x] = cmd.attribute;
               cur_x++;
               if (cur_x >= COLS) begin
                  cur_x = 0;
                  cur_y++;
               end
            end
            if (cur_y >= NROWS) scroll_grid();
         end
         ACT_CLEAR: begin
            blank_grid();
            cur_x = indent_eff();
            cur_y = home_eff();
         end
         ACT_READ: begin
            // cells off the grid read as zero
            if (int'(cmd.read_row) < NROWS && int'(cmd.read_col) < COLS) begin
               reply.cell_word = {grid_attr[cmd.read_row][cmd.read_col],
                                  grid_char[cmd.read_row][cmd.read_col]};
            end
         end
         default: ;
      endcase
      reply.cursor_col = cur_x[COL_W-1:0];
      reply.cursor_row = cur_y[ROW_W-1:0];
   endtask

   // ------------------------------------------------------------------
   // Word builders
   // ------------------------------------------------------------------
   function automatic console_cmd_type make_cmd(input logic [ACTION_W-1:0] action,
                                                input logic [CHAR_W-1:0] ch,
                                                input logic [ATTR_W-1:0] attr,
                                                input logic [ROW_W-1:0] row,
                                                input logic [COL_W-1:0] col);
      console_cmd_type cmd;
      cmd.action    = action;
      cmd.char_code = ch;
      cmd.attribute = attr;
      cmd.read_row  = row;
      cmd.read_col  = col;
      return cmd;
   endfunction

   // Mostly text with newlines, reads biased toward what was just written,
   // the odd clear, off-grid read and no-op action.
   function automatic console_cmd_type random_cmd();
      console_cmd_type cmd;
      int              pick;
      int              row;
      int              col;
      cmd.action    = ACT_PUT;
      cmd.char_code = 8'($urandom_range(0, 255));
      cmd.attribute = 8'($urandom_range(0, 255));
      cmd.read_row  = 5'($urandom_range(0, 31));
      cmd.read_col  = 7'($urandom_range(0, 127));
      pick = $urandom_range(0, 999);
      if (pick < 350) begin
         cmd.char_code = 8'($urandom_range(FIRST_PRINTABLE, LAST_PRINTABLE));
      end else if (pick < 550) begin
         // any byte at all, newline included
      end else if (pick < 700) begin
         cmd.char_code = NEWLINE_CHAR;
      end else if (pick < 705) begin
         cmd.action = ACT_CLEAR;
      end else if (pick < 980) begin
         cmd.action = ACT_READ;
         if ($urandom_range(0, 9) == 0) begin
            // keep the full-width random row/col, often off the grid
         end else if ($urandom_range(0, 1) == 0) begin
            row = cur_y - int'($urandom_range(0, 1));
            col = cur_x - int'($urandom_range(1, 3));
            if (row < 0) row = 0;
            if (col < 0) col = 0;
            cmd.read_row = row[ROW_W-1:0];
            cmd.read_col = col[COL_W-1:0];
         end else begin
            cmd.read_row = 5'($urandom_range(0, NROWS - 1));
            cmd.read_col = 7'($urandom_range(0, COLS - 1));
         end
      end else begin
         cmd.action = ACT_NONE;
      end
      return cmd;
   endfunction

   // ------------------------------------------------------------------
   // Request side. Called at a falling edge, returns at one with valid
   // possibly still high so that back-to-back words keep it up.
   // ------------------------------------------------------------------
   task automatic send_word(input console_cmd_type cmd);
      console_reply_type reply;
      int                gap;
      req_bus.valid     <= 1'b1;
      req_bus.action    <= cmd.action;
      req_bus.char_code <= cmd.char_code;
      req_bus.attribute <= cmd.attribute;
      req_bus.read_row  <= cmd.read_row;
      req_bus.read_col  <= cmd.read_col;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      advance_console(cmd, reply);
      reply_q.push_back(reply);
      @(negedge clock);
      gap = 0;
      if (!calm && $urandom_range(1, 100) <= send_idle_pct) gap = $urandom_range(1, 13);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // drop valid and wait for every expected reply
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (reply_q.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // register write; only called with the console idle
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      set_console_reg(idx, value);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Response side: ready changes on the falling edge.
   // A hold request forces a long stall; otherwise random bursts.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (!calm && $urandom_range(1, 100) <= stall_pct) begin
         stall_left = $urandom_range(0, 12);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Reply checker: each accepted reply against the oldest expectation.
   always @(posedge clock) begin : check_reply
      console_reply_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (reply_q.size() == 0) begin
            $display("%0t: reply with none expected: word %h col %0d row %0d", $time,
                     rsp_bus.cell_word, rsp_bus.cursor_col, rsp_bus.cursor_row);
            mismatch_count++;
         end else begin
            want = reply_q.pop_front();
            if (rsp_bus.cell_word !== want.cell_word) begin
               $display("%0t: cell_word expected %h actual %h", $time,
                        want.cell_word, rsp_bus.cell_word);
               mismatch_count++;
            end
            if (rsp_bus.cursor_col !== want.cursor_col) begin
               $display("%0t: cursor_col expected %0d actual %0d", $time,
                        want.cursor_col, rsp_bus.cursor_col);
               mismatch_count++;
            end
            if (rsp_bus.cursor_row !== want.cursor_row) begin
               $display("%0t: cursor_row expected %0d actual %0d", $time,
                        want.cursor_row, rsp_bus.cursor_row);
               mismatch_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Fresh grid after reset: blanks, cursor at indent 2 / home 1,
   // off-grid reads and the no-op action.
   task automatic test_reset_state();
      send_word(make_cmd(ACT_READ, 8'h00, 8'h00, 5'd0, 7'd0));
      send_word(make_cmd(ACT_READ, 8'hFF, 8'hFF, 5'd24, 7'd79));
      send_word(make_cmd(ACT_NONE, 8'hFF, 8'hFF, 5'd31, 7'd127));
      send_word(make_cmd(ACT_READ, 8'h00, 8'h00, 5'd25, 7'd0));
      send_word(make_cmd(ACT_READ, 8'h00, 8'h00, 5'd0, 7'd80));
      send_word(make_cmd(ACT_READ, 8'h00, 8'h00, 5'd31, 7'd127));
      drain();
   endtask

   // Byte extremes stored unsigned, attributes at both ends, newline to indent.
   task automatic test_put_bytes();
      send_word(make_cmd(ACT_PUT, 8'h41, 8'h1F, 5'd0, 7'd0));
      send_word(make_cmd(ACT_PUT, 8'hFF, 8'hFF, 5'd31, 7'd127));
      send_word(make_cmd(ACT_PUT, 8'h00, 8'h00, 5'd0, 7'd0));
      send_word(make_cmd(ACT_PUT, 8'h80, 8'h80, 5'd0, 7'd0));
      send_word(make_cmd(ACT_PUT, NEWLINE_CHAR, 8'hA5, 5'd0, 7'd0));
      send_word(make_cmd(ACT_READ, 8'h00, 8'h00, 5'd1, 7'd2));
      send_word(make_cmd(ACT_READ, 8'h00, 8'h00, 5'd1, 7'd3));
      send_word(make_cmd(ACT_READ, 8'h00, 8'h00, 5'd1, 7'd4));
      send_word(make_cmd(ACT_READ, 8'h00, 8'h00, 5'd1, 7'd5));
      drain();
   endtask

   // Registers at their extremes: both clamp to the last column/row.
   // A register write leaves the cursor alone; clear picks it up.
   // A put at the bottom-right corner wraps straight into a scroll.
   task automatic test_register_extremes();
      write_reg(CSR_INDENT, 8'hFF);
      write_reg(CSR_HOME, 8'hFF);
      send_word(make_cmd(ACT_READ, 8'h00, 8'h00, 5'd1, 7'd2));
      send_word(make_cmd(ACT_CLEAR, 8'h00, 8'h00, 5'd0, 7'd0));
      send_word(make_cmd(ACT_PUT, 8'h5A, 8'h4E, 5'd0, 7'd0));
      send_word(make_cmd(ACT_READ, 8'h00, 8'h00, 5'd23, 7'd79));
      send_word(make_cmd(ACT_PUT, NEWLINE_CHAR, 8'h00, 5'd0, 7'd0));
      send_word(make_cmd(ACT_READ, 8'h00, 8'h00, 5'd22, 7'd79));
      send_word(make_cmd(ACT_READ, 8'h00, 8'h00, 5'd24, 7'd79));
      drain();
      write_reg(CSR_INDENT, 8'h00);
      write_reg(CSR_HOME, 8'h00);
      send_word(make_cmd(ACT_CLEAR, 8'h00, 8'h00, 5'd0, 7'd0));
      send_word(make_cmd(ACT_PUT, 8'h7E, 8'h07, 5'd0, 7'd0));
      send_word(make_cmd(ACT_READ, 8'h00, 8'h00, 5'd0, 7'd0));
      drain();
   endtask

   // Receiver holds off for a long stretch while words keep coming, so the
   // response register and the input both back up.
   task automatic test_backpressure();
      send_idle_pct = 0;
      hold_request  = 200;
      for (int i = 0; i < 30; i++) send_word(random_cmd());
      drain();
      send_idle_pct = 20;
   endtask

   // One random phase under given register values and idling rates.
   task automatic test_random_text(input int n_words,
                                   input logic [CSR_DATA_W-1:0] indent_val,
                                   input logic [CSR_DATA_W-1:0] home_val,
                                   input int idle_pct,
                                   input int stall_rate);
      write_reg(CSR_INDENT, indent_val);
      write_reg(CSR_HOME, home_val);
      send_idle_pct = idle_pct;
      stall_pct     = stall_rate;
      // start from a known screen half the time, otherwise keep the old one
      if ($urandom_range(0, 1) == 0) send_word(make_cmd(ACT_CLEAR, 8'h00, 8'h00, 5'd0, 7'd0));
      for (int i = 0; i < n_words; i++) send_word(random_cmd());
      drain();
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.action    = ACT_PUT;
      req_bus.char_code = '0;
      req_bus.attribute = '0;
      req_bus.read_row  = '0;
      req_bus.read_col  = '0;
      rsp_bus.ready     = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = CSR_INDENT;
      csr_bus.data      = '0;
      reset_console();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_put_bytes();
      test_register_extremes();
      test_backpressure();

      // register settings: edges of the grid, just past them, random, zero
      test_random_text(200, 8'd79, 8'd24, 30, 30);
      test_random_text(200, 8'd80, 8'd25, 10, 40);
      test_random_text(200, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 0, 0);
      test_random_text(200, 8'd0, 8'd0, 40, 10);
      test_random_text(200, 8'($urandom_range(0, 79)), 8'($urandom_range(0, 24)), 20, 20);

      // last stretch runs flat out on both sides
      calm = 1'b1;
      test_random_text(200, INDENT_RESET, HOME_RESET, 0, 0);

      // allow for a stray late reply: one row sweep plus pipeline
      repeat (COLS + 8) @(posedge clock);
      if (reply_q.size() != 0) $display("%0t: %0d replies never arrived", $time, reply_q.size());
      if (mismatch_count == 0 && reply_q.size() == 0) begin
         $display("** text_console_writer: PASSED **");
      end else begin
         $display("** text_console_writer: FAILED **");
      end
      $finish;
   end

   // hang guard, several times the slowest legal run
   initial begin
      #2000000;
      $display("%0t: timeout, %0d replies outstanding", $time, reply_q.size());
      $display("** text_console_writer: FAILED **");
      $finish;
   end

endmodule
